[src/teit_pkg.sv]
`timescale 1ns / 1ps
package teit_pkg;

	localparam int TEIT_CHANNELS = 64;

	localparam int WORD_W    = 32;
	localparam int TIME_W    = 40;
	localparam int DIFF_W    = 41;
	localparam int GAP_W     = 42;
	localparam int CH_W      = 6;
	localparam int KIND_W    = 4;
	localparam int EPOCH_W   = 15;
	localparam int TS_W      = 23;
	localparam int IDX_W     = 7;
	localparam int CFG_IDX_W = 3;

	// candidate results of one hit: own-channel kinds, then six per valve
	localparam int NCAND       = 15;
	localparam int CAND_W      = 4;
	localparam int VALVE_BASE  = 3;
	localparam int VALVE_SPAN  = 6;
	localparam int MAX_RESULTS = 4;
	localparam int CNT_W       = 2;

	localparam logic [CFG_IDX_W-1:0] REG_GAP_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_A_OPEN        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_A_CLOSE       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_A_DRIVE       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_B_OPEN        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_B_CLOSE       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_B_DRIVE       = 3'd6;

	localparam logic [KIND_W-1:0] KIND_RISE_PERIOD  = 4'd0;
	localparam logic [KIND_W-1:0] KIND_FALL_PERIOD  = 4'd1;
	localparam logic [KIND_W-1:0] KIND_FALL_TO_RISE = 4'd2;
	localparam logic [KIND_W-1:0] KIND_DRIVE_CLOSE  = 4'd3;
	localparam logic [KIND_W-1:0] KIND_DRIVE_OPEN   = 4'd4;
	localparam logic [KIND_W-1:0] KIND_CLOSE_OPEN   = 4'd5;
	localparam logic [KIND_W-1:0] KIND_NODRIVE_CLOSE = 4'd6;
	localparam logic [KIND_W-1:0] KIND_NODRIVE_OPEN = 4'd7;
	localparam logic [KIND_W-1:0] KIND_OPEN_CLOSE   = 4'd8;

	localparam logic [7:0] ROLLOVER_TAG = 8'hff;
	localparam logic [1:0] HIT_TAG      = 2'b10;
	localparam logic       EDGE_RISE    = 1'b0;
	localparam logic       EDGE_FALL    = 1'b1;

	localparam logic [TIME_W-1:0] RST_GAP_THRESHOLD = 40'd10000000;
	localparam logic [CH_W-1:0]   RST_A_OPEN  = 6'd8;
	localparam logic [CH_W-1:0]   RST_A_CLOSE = 6'd9;
	localparam logic [CH_W-1:0]   RST_A_DRIVE = 6'd25;
	localparam logic [CH_W-1:0]   RST_B_OPEN  = 6'd10;
	localparam logic [CH_W-1:0]   RST_B_CLOSE = 6'd11;
	localparam logic [CH_W-1:0]   RST_B_DRIVE = 6'd26;

	typedef struct packed {
		logic [TIME_W-1:0] gap_threshold;
		logic [CH_W-1:0]   a_open;
		logic [CH_W-1:0]   a_close;
		logic [CH_W-1:0]   a_drive;
		logic [CH_W-1:0]   b_open;
		logic [CH_W-1:0]   b_close;
		logic [CH_W-1:0]   b_drive;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GAP,
		ST_EMIT
	} seq_state_t;

endpackage

[src/teit_in_buf.sv]
`timescale 1ns / 1ps
module teit_in_buf (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [teit_pkg::WORD_W-1:0] data_word,
	output logic                       word_valid,
	output logic [teit_pkg::WORD_W-1:0] word,
	input  logic                       word_take
);
	import teit_pkg::*;

	logic              valid_q;
	logic [WORD_W-1:0] word_q;

	// accept the next word in the cycle the engine retires the held one
	assign in_ready   = !valid_q || word_take;
	assign word_valid = valid_q;
	assign word       = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_q <= 1'b1;
		end else if (word_take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_q <= data_word;
		end
	end

endmodule

[src/teit_edge_ram.sv]
`timescale 1ns / 1ps
module teit_edge_ram #(
	parameter int DEPTH = 2 * teit_pkg::TEIT_CHANNELS,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [teit_pkg::TIME_W-1:0] wdata,
	input  logic                       re,
	input  logic [AW-1:0]              raddr,
	output logic [teit_pkg::TIME_W-1:0] rdata
);
	import teit_pkg::*;

	logic [TIME_W-1:0] mem [DEPTH];
	logic [TIME_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold read data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/teit_seq.sv]
`timescale 1ns / 1ps
module teit_seq #(
	parameter int CHANNELS = teit_pkg::TEIT_CHANNELS,
	localparam int AW = $clog2(2 * CHANNELS)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  teit_pkg::cfg_t                    cfg,
	input  logic                              word_valid,
	input  logic [teit_pkg::WORD_W-1:0]       word,
	output logic                              word_take,
	output logic                              ram_we,
	output logic [AW-1:0]                     ram_waddr,
	output logic [teit_pkg::TIME_W-1:0]       ram_wdata,
	output logic                              ram_re,
	output logic [AW-1:0]                     ram_raddr,
	input  logic [teit_pkg::TIME_W-1:0]       ram_rdata,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [teit_pkg::KIND_W-1:0]       interval_kind,
	output logic [teit_pkg::CH_W-1:0]         hit_channel,
	output logic signed [teit_pkg::DIFF_W-1:0] interval_ticks,
	output logic                              reference_valid,
	output logic                              last_result
);
	import teit_pkg::*;

	localparam int DEPTH = 2 * CHANNELS;

	seq_state_t state_q, state_d;

	logic [EPOCH_W-1:0] epoch_q;
	logic [CH_W-1:0]    ch_q;
	logic               edge_q;
	logic [TIME_W-1:0]  now_q;
	logic [NCAND-1:0]   mask_q;
	logic [CAND_W-1:0]  sel_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DEPTH-1:0]   flags_q;

	logic               out_valid_q;
	logic [KIND_W-1:0]  kind_q;
	logic [CH_W-1:0]    chan_q;
	logic [DIFF_W-1:0]  ticks_q;
	logic               refv_q;
	logic               last_q;

	logic               is_roll, is_hit, in_range;
	logic [CH_W-1:0]    w_ch;
	logic [TS_W-1:0]    w_ts;
	logic               w_edge;
	logic [TIME_W-1:0]  now_c;

	logic [IDX_W-1:0]   own_idx;
	logic [GAP_W-1:0]   gap_diff;
	logic               gap;

	logic [KIND_W-1:0]  cand_kind [NCAND];
	logic [IDX_W-1:0]   cand_ref  [NCAND];
	logic [NCAND-1:0]   cand_en;
	logic [CH_W-1:0]    vop [2];
	logic [CH_W-1:0]    vcl [2];
	logic [CH_W-1:0]    vdr [2];

	logic [NCAND-1:0]   iss_mask, iss_rest;
	logic [CAND_W-1:0]  iss_sel;
	logic               out_free;
	logic               emit_last;
	logic               capture, issue, finish, load_out;
	logic               cur_refv;
	logic [DIFF_W-1:0]  cur_ticks;

	function automatic logic seen_at(input logic [IDX_W-1:0] idx,
	                                 input logic [DEPTH-1:0] fl);
		return ({1'b0, idx[IDX_W-1:1]} < IDX_W'(CHANNELS)) && fl[idx[AW-1:0]];
	endfunction

	function automatic logic [CAND_W-1:0] first_set(input logic [NCAND-1:0] m);
		logic [CAND_W-1:0] r;
		r = '0;
		for (int i = NCAND - 1; i >= 0; i--) begin
			if (m[i]) begin
				r = CAND_W'(i);
			end
		end
		return r;
	endfunction

	assign is_roll  = word[31:24] == ROLLOVER_TAG;
	assign is_hit   = word[31:30] == HIT_TAG;
	assign w_ch     = word[29:24];
	assign w_ts     = word[23:1];
	assign w_edge   = word[0];
	assign in_range = {1'b0, w_ch} < IDX_W'(CHANNELS);

	// timestamp + epoch * (2^23 - 1)
	assign now_c = TIME_W'({epoch_q, {TS_W{1'b0}}}) - TIME_W'(epoch_q) + TIME_W'(w_ts);

	assign own_idx  = {ch_q, edge_q};
	assign gap_diff = {2'b00, now_q} - {2'b00, ram_rdata};
	assign gap      = !seen_at(own_idx, flags_q) ||
	                  ($signed(gap_diff) > $signed({2'b00, cfg.gap_threshold}));

	assign vop[0] = cfg.a_open;
	assign vcl[0] = cfg.a_close;
	assign vdr[0] = cfg.a_drive;
	assign vop[1] = cfg.b_open;
	assign vcl[1] = cfg.b_close;
	assign vdr[1] = cfg.b_drive;

	// candidate list in emission order
	always_comb begin
		cand_kind[0] = KIND_RISE_PERIOD;
		cand_ref[0]  = {ch_q, EDGE_RISE};
		cand_en[0]   = (edge_q == EDGE_RISE) && seen_at({ch_q, EDGE_RISE}, flags_q);
		cand_kind[1] = KIND_FALL_TO_RISE;
		cand_ref[1]  = {ch_q, EDGE_FALL};
		cand_en[1]   = (edge_q == EDGE_RISE) && seen_at({ch_q, EDGE_FALL}, flags_q);
		cand_kind[2] = KIND_FALL_PERIOD;
		cand_ref[2]  = {ch_q, EDGE_FALL};
		cand_en[2]   = (edge_q == EDGE_FALL) && seen_at({ch_q, EDGE_FALL}, flags_q);
		for (int v = 0; v < 2; v++) begin
			cand_kind[VALVE_BASE + VALVE_SPAN*v]     = KIND_DRIVE_CLOSE;
			cand_ref[VALVE_BASE + VALVE_SPAN*v]      = {vdr[v], EDGE_RISE};
			cand_en[VALVE_BASE + VALVE_SPAN*v]       = gap && ch_q == vcl[v] &&
			                                           edge_q == EDGE_FALL;
			cand_kind[VALVE_BASE + VALVE_SPAN*v + 1] = KIND_DRIVE_OPEN;
			cand_ref[VALVE_BASE + VALVE_SPAN*v + 1]  = {vdr[v], EDGE_RISE};
			cand_en[VALVE_BASE + VALVE_SPAN*v + 1]   = gap && ch_q == vop[v] &&
			                                           edge_q == EDGE_RISE;
			cand_kind[VALVE_BASE + VALVE_SPAN*v + 2] = KIND_CLOSE_OPEN;
			cand_ref[VALVE_BASE + VALVE_SPAN*v + 2]  = {vcl[v], EDGE_FALL};
			cand_en[VALVE_BASE + VALVE_SPAN*v + 2]   = gap && ch_q == vop[v] &&
			                                           edge_q == EDGE_RISE;
			cand_kind[VALVE_BASE + VALVE_SPAN*v + 3] = KIND_NODRIVE_CLOSE;
			cand_ref[VALVE_BASE + VALVE_SPAN*v + 3]  = {vdr[v], EDGE_FALL};
			cand_en[VALVE_BASE + VALVE_SPAN*v + 3]   = gap && ch_q == vcl[v] &&
			                                           edge_q == EDGE_RISE;
			cand_kind[VALVE_BASE + VALVE_SPAN*v + 4] = KIND_OPEN_CLOSE;
			cand_ref[VALVE_BASE + VALVE_SPAN*v + 4]  = {vop[v], EDGE_FALL};
			cand_en[VALVE_BASE + VALVE_SPAN*v + 4]   = gap && ch_q == vcl[v] &&
			                                           edge_q == EDGE_RISE;
			cand_kind[VALVE_BASE + VALVE_SPAN*v + 5] = KIND_NODRIVE_OPEN;
			cand_ref[VALVE_BASE + VALVE_SPAN*v + 5]  = {vdr[v], EDGE_FALL};
			cand_en[VALVE_BASE + VALVE_SPAN*v + 5]   = gap && ch_q == vop[v] &&
			                                           edge_q == EDGE_FALL;
		end
	end

	assign iss_mask  = (state_q == ST_GAP) ? cand_en : mask_q;
	assign iss_sel   = first_set(iss_mask);
	assign iss_rest  = iss_mask & ~(NCAND'(1) << iss_sel);
	assign out_free  = !out_valid_q || out_ready;
	assign emit_last = (mask_q == '0) || (cnt_q == CNT_W'(MAX_RESULTS - 1));

	always_comb begin
		state_d   = state_q;
		word_take = 1'b0;
		capture   = 1'b0;
		issue     = 1'b0;
		finish    = 1'b0;
		load_out  = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = cand_ref[iss_sel][AW-1:0];
		case (state_q)
			ST_IDLE: begin
				ram_raddr = AW'({w_ch, w_edge});
				if (word_valid) begin
					if (is_hit && in_range) begin
						capture = 1'b1;
						ram_re  = 1'b1;
						state_d = ST_GAP;
					end else begin
						word_take = 1'b1;
					end
				end
			end
			ST_GAP: begin
				if (cand_en == '0) begin
					finish = 1'b1;
				end else begin
					issue = 1'b1;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					load_out = 1'b1;
					if (emit_last) begin
						finish = 1'b1;
					end else begin
						issue = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (issue) begin
			ram_re  = 1'b1;
			state_d = ST_EMIT;
		end
		if (finish) begin
			word_take = 1'b1;
			state_d   = ST_IDLE;
		end
	end

	assign ram_we    = finish;
	assign ram_waddr = own_idx[AW-1:0];
	assign ram_wdata = now_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q <= '0;
			flags_q <= '0;
		end else begin
			if (state_q == ST_IDLE && word_valid && is_roll) begin
				epoch_q <= word[15:1];
			end
			if (finish) begin
				flags_q[own_idx[AW-1:0]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			ch_q   <= w_ch;
			edge_q <= w_edge;
			now_q  <= now_c;
		end
		if (issue) begin
			sel_q  <= iss_sel;
			mask_q <= iss_rest;
			cnt_q  <= (state_q == ST_GAP) ? '0 : cnt_q + CNT_W'(1);
		end
	end

	// read data now holds the reference entry of the selected candidate
	assign cur_refv  = seen_at(cand_ref[sel_q], flags_q);
	assign cur_ticks = cur_refv ? ({1'b0, now_q} - {1'b0, ram_rdata}) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			kind_q  <= cand_kind[sel_q];
			chan_q  <= ch_q;
			ticks_q <= cur_ticks;
			refv_q  <= cur_refv;
			last_q  <= emit_last;
		end
	end

	assign out_valid       = out_valid_q;
	assign interval_kind   = kind_q;
	assign hit_channel     = chan_q;
	assign interval_ticks  = $signed(ticks_q);
	assign reference_valid = refv_q;
	assign last_result     = last_q;

endmodule

[src/tdc_edge_interval_tracker.sv]
// channel   signals                                 word
// ------    -------------------------------------   ------------------------------
// input     in_valid / in_ready, data_word           one converter word
// result    out_valid / out_ready, interval_kind,    one interval, last_result on
//           hit_channel, interval_ticks,             the final one of a word
//           reference_valid, last_result
// config    cfg_we, cfg_index, cfg_wdata             one register write, no wait
//
// A hit word with n results (0 to 4) holds the engine for one step that reads its
// own edge time, one that checks the gap, then one store read per result through
// the single read port. Rollover and ignored words are retired from the idle state.
// Reset clears the epoch, the edge-seen flags and loads the register defaults; the
// edge time store is not cleared, every read of it is gated by its flag.
// The input buffer holds the word in work and takes the next one in the cycle the
// engine retires it, so words follow with no gap; a stalled result holds the engine
// in its emit step.
`timescale 1ns / 1ps
module tdc_edge_interval_tracker #(
	parameter int CHANNELS = teit_pkg::TEIT_CHANNELS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [teit_pkg::WORD_W-1:0]         data_word,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [teit_pkg::KIND_W-1:0]         interval_kind,
	output logic [teit_pkg::CH_W-1:0]           hit_channel,
	output logic signed [teit_pkg::DIFF_W-1:0]  interval_ticks,
	output logic                                reference_valid,
	output logic                                last_result,
	input  logic                                cfg_we,
	input  logic [teit_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [teit_pkg::TIME_W-1:0]         cfg_wdata
);
	import teit_pkg::*;

	localparam int AW = $clog2(2 * CHANNELS);

	cfg_t              cfg_q;
	logic              word_valid;
	logic [WORD_W-1:0] word;
	logic              word_take;
	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [TIME_W-1:0] ram_wdata, ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gap_threshold <= RST_GAP_THRESHOLD;
			cfg_q.a_open        <= RST_A_OPEN;
			cfg_q.a_close       <= RST_A_CLOSE;
			cfg_q.a_drive       <= RST_A_DRIVE;
			cfg_q.b_open        <= RST_B_OPEN;
			cfg_q.b_close       <= RST_B_CLOSE;
			cfg_q.b_drive       <= RST_B_DRIVE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAP_THRESHOLD: cfg_q.gap_threshold <= cfg_wdata;
				REG_A_OPEN:        cfg_q.a_open  <= cfg_wdata[CH_W-1:0];
				REG_A_CLOSE:       cfg_q.a_close <= cfg_wdata[CH_W-1:0];
				REG_A_DRIVE:       cfg_q.a_drive <= cfg_wdata[CH_W-1:0];
				REG_B_OPEN:        cfg_q.b_open  <= cfg_wdata[CH_W-1:0];
				REG_B_CLOSE:       cfg_q.b_close <= cfg_wdata[CH_W-1:0];
				REG_B_DRIVE:       cfg_q.b_drive <= cfg_wdata[CH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	teit_in_buf u_in_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_word  (data_word),
		.word_valid (word_valid),
		.word       (word),
		.word_take  (word_take)
	);

	teit_edge_ram #(
		.DEPTH (2 * CHANNELS)
	) u_edge_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	teit_seq #(
		.CHANNELS (CHANNELS)
	) u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.word_valid      (word_valid),
		.word            (word),
		.word_take       (word_take),
		.ram_we          (ram_we),
		.ram_waddr       (ram_waddr),
		.ram_wdata       (ram_wdata),
		.ram_re          (ram_re),
		.ram_raddr       (ram_raddr),
		.ram_rdata       (ram_rdata),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.interval_kind   (interval_kind),
		.hit_channel     (hit_channel),
		.interval_ticks  (interval_ticks),
		.reference_valid (reference_valid),
		.last_result     (last_result)
	);

	a_write_retires_word: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> word_take)
		else $error("edge time written without retiring the word");

	a_no_read_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("store read issued in the retiring cycle");

	a_take_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		word_take |-> word_valid)
		else $error("engine retired an empty buffer");

	a_unset_ref_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !reference_valid |-> interval_ticks == '0)
		else $error("interval nonzero for an unset reference");

endmodule
